### rtl/csa_pkg.sv
// Shared types and constants of the cross spectrum accumulator.
`default_nettype none
package csa_pkg;

    localparam int DEF_MAX_X_POINTS = 256;
    localparam int DEF_MAX_Y_POINTS = 256;
    localparam int DEF_LEVELS       = 64;
    localparam int DEF_ACC_BITS     = 48;

    localparam int GRID_W     = 13;
    localparam int CFG_W      = 9;
    localparam int PROD_W     = 33;
    localparam int OUT_W      = 48;
    localparam int CMD_DEPTH  = 4;
    localparam int RES_DEPTH  = 2;

    localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

    localparam logic [0:0] REG_GRID_X = 1'b0;
    localparam logic [0:0] REG_GRID_Y = 1'b1;

    localparam logic [1:0] OP_ACCUM  = 2'd0;
    localparam logic [1:0] OP_READ_X = 2'd1;
    localparam logic [1:0] OP_READ_Y = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         x_wave_index;
        logic [7:0]         y_wave_index;
        logic [5:0]         z_level;
        logic signed [15:0] u_real;
        logic signed [15:0] u_imag;
        logic signed [15:0] v_real;
        logic signed [15:0] v_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] bin_real;
        logic signed [OUT_W-1:0] bin_imag;
    } t_out_word;

    typedef struct packed {
        logic do_x;
        logic do_y;
        logic do_f;
        logic rd_x;
        logic rd_y;
        logic rd_zero;
    } t_cmd_flags;

endpackage
`default_nettype wire

### rtl/csa_queue.sv
// Small synchronous FIFO used between the front, the back and the result port.
`default_nettype none
module csa_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic              o_full,
    output logic [W-1:0]      o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

### rtl/csa_front.sv
// Front end: takes words, forms the cross products and classifies bin updates.
`default_nettype none
module csa_front #(
    parameter int MAX_X_POINTS = csa_pkg::DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = csa_pkg::DEF_MAX_Y_POINTS,
    parameter int LEVELS       = csa_pkg::DEF_LEVELS,
    parameter int AXW          = 13,
    parameter int AYW          = 13,
    parameter int CMD_W        = 100
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire csa_pkg::t_in_word           i_in_word,
    output logic                             o_full,
    input  wire logic                        i_hold,
    input  wire logic                        i_cfg_we,
    input  wire logic [0:0]                  i_cfg_index,
    input  wire logic [csa_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                             o_q_push,
    input  wire logic                        i_q_full,
    output logic [CMD_W-1:0]                 o_q_data
);
    localparam int GW = csa_pkg::GRID_W;
    localparam int PW = csa_pkg::PROD_W;

    logic [csa_pkg::CFG_W-1:0] r_grid_x, r_grid_y;
    logic                      r_s1_valid;
    logic [1:0]                r_op;
    logic [7:0]                r_ix, r_iy;
    logic [5:0]                r_k;
    logic signed [31:0]        r_p_rr, r_p_ii, r_p_ir, r_p_ri;

    logic                      w_adv, w_accept;
    logic [GW-1:0]             w_nx, w_ny, w_hx, w_hy, w_ix, w_iy, w_niy;
    logic                      w_k_ok, w_pt_ok;
    logic signed [PW-1:0]      w_re, w_im;
    logic [AXW-1:0]            w_x_addr;
    logic [AYW-1:0]            w_y_addr, w_f_addr;
    csa_pkg::t_cmd_flags       w_flags;

    assign w_adv    = !r_s1_valid || !i_q_full;
    assign o_full   = (r_s1_valid && i_q_full) || i_hold;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_s1_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_grid_x   <= csa_pkg::GRID_RESET;
            r_grid_y   <= csa_pkg::GRID_RESET;
        end else begin
            if (w_adv) begin
                r_s1_valid <= w_accept;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    csa_pkg::REG_GRID_X: r_grid_x <= i_cfg_data;
                    csa_pkg::REG_GRID_Y: r_grid_y <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_accept) begin
            r_op   <= i_in_word.operation;
            r_ix   <= i_in_word.x_wave_index;
            r_iy   <= i_in_word.y_wave_index;
            r_k    <= i_in_word.z_level;
            r_p_rr <= i_in_word.u_real * i_in_word.v_real;
            r_p_ii <= i_in_word.u_imag * i_in_word.v_imag;
            r_p_ir <= i_in_word.u_imag * i_in_word.v_real;
            r_p_ri <= i_in_word.u_real * i_in_word.v_imag;
        end
    end

    always_comb begin
        if (r_grid_x == '0) begin
            w_nx = GW'(1);
        end else if (GW'(r_grid_x) > GW'(MAX_X_POINTS)) begin
            w_nx = GW'(MAX_X_POINTS);
        end else begin
            w_nx = GW'(r_grid_x);
        end
        if (r_grid_y == '0) begin
            w_ny = GW'(1);
        end else if (GW'(r_grid_y) > GW'(MAX_Y_POINTS)) begin
            w_ny = GW'(MAX_Y_POINTS);
        end else begin
            w_ny = GW'(r_grid_y);
        end
    end

    assign w_hx    = w_nx >> 1;
    assign w_hy    = w_ny >> 1;
    assign w_ix    = GW'(r_ix);
    assign w_iy    = GW'(r_iy);
    assign w_niy   = (r_iy == '0) ? '0 : w_ny - w_iy;
    assign w_k_ok  = 32'(r_k) < LEVELS;
    assign w_pt_ok = (w_ix <= w_hx) && (w_iy < w_ny) && w_k_ok;

    assign w_re = PW'(r_p_rr) + PW'(r_p_ii);
    assign w_im = PW'(r_p_ir) - PW'(r_p_ri);

    assign w_x_addr = AXW'(32'(r_ix) * LEVELS + 32'(r_k));
    assign w_y_addr = AYW'(32'(r_iy) * LEVELS + 32'(r_k));
    assign w_f_addr = AYW'(32'(w_niy) * LEVELS + 32'(r_k));

    always_comb begin
        w_flags = '0;
        unique case (r_op)
            csa_pkg::OP_ACCUM: begin
                if (w_pt_ok) begin
                    w_flags.do_x = !(r_ix == '0 && r_iy == '0);
                    w_flags.do_y = (w_iy <= w_hy) && ((r_ix != '0) || (r_iy != '0));
                    w_flags.do_f = (r_ix != '0) && !((w_ix == w_hx) && !w_nx[0])
                                   && (w_niy <= w_hy);
                end
            end
            csa_pkg::OP_READ_X: begin
                if ((32'(r_ix) <= MAX_X_POINTS / 2) && w_k_ok) begin
                    w_flags.rd_x = 1'b1;
                end else begin
                    w_flags.rd_zero = 1'b1;
                end
            end
            csa_pkg::OP_READ_Y: begin
                if ((32'(r_iy) <= MAX_Y_POINTS / 2) && w_k_ok) begin
                    w_flags.rd_y = 1'b1;
                end else begin
                    w_flags.rd_zero = 1'b1;
                end
            end
            default: begin
                w_flags = '0;
            end
        endcase
    end

    assign o_q_data = {w_flags, w_x_addr, w_y_addr, w_f_addr, w_re, w_im};

endmodule
`default_nettype wire

### rtl/csa_back.sv
// Back end: clears the bin stores after reset and runs read-modify-write updates.
`default_nettype none
module csa_back #(
    parameter int ACC_BITS = csa_pkg::DEF_ACC_BITS,
    parameter int X_DEPTH  = 8256,
    parameter int Y_DEPTH  = 8256,
    parameter int AXW      = 14,
    parameter int AYW      = 14,
    parameter int CMD_W    = 100
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire logic [CMD_W-1:0]   i_q_data,
    output logic                    o_q_pop,
    output logic                    o_clearing,
    input  wire logic               i_out_full,
    output logic                    o_out_push,
    output csa_pkg::t_out_word      o_out_word
);
    localparam int PW        = csa_pkg::PROD_W;
    localparam int CLR_DEPTH = (X_DEPTH > Y_DEPTH) ? X_DEPTH : Y_DEPTH;
    localparam int CW        = $clog2(CLR_DEPTH);
    localparam int MW        = 2 * ACC_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RD    = 2'd2;
    localparam logic [1:0] S_WR    = 2'd3;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_F = 2'd2;

    logic [MW-1:0] r_x_mem [X_DEPTH];
    logic [MW-1:0] r_y_mem [Y_DEPTH];

    logic [1:0]           r_state, r_sel;
    logic [CW-1:0]        r_clr;
    logic                 r_pend_x, r_pend_y, r_pend_f, r_is_read;
    logic [AXW-1:0]       r_x_addr;
    logic [AYW-1:0]       r_y_addr, r_f_addr;
    logic signed [PW-1:0] r_re, r_im;
    logic [MW-1:0]        r_x_q, r_y_q;

    csa_pkg::t_cmd_flags  w_flags;
    logic [AXW-1:0]       w_x_addr;
    logic [AYW-1:0]       w_y_addr, w_f_addr, w_y_rd_addr, w_y_wa;
    logic signed [PW-1:0] w_re, w_im, w_dim;
    logic [1:0]           w_sel;
    logic [MW-1:0]        w_old, w_new, w_x_wd, w_y_wd;
    logic                 w_x_we, w_y_we, w_zero_push;
    logic [AXW-1:0]       w_x_wa;

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [PW-1:0]       d
    );
        logic signed [ACC_BITS:0] s;
        s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(d);
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                               : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return s[ACC_BITS-1:0];
    endfunction

    function automatic logic signed [csa_pkg::OUT_W-1:0] to_out(
        input logic signed [ACC_BITS-1:0] a
    );
        logic signed [ACC_BITS+csa_pkg::OUT_W-1:0] e;
        e = (ACC_BITS+csa_pkg::OUT_W)'(a);
        return e[csa_pkg::OUT_W-1:0];
    endfunction

    assign {w_flags, w_x_addr, w_y_addr, w_f_addr, w_re, w_im} = i_q_data;

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty && !i_out_full;
    assign w_zero_push = o_q_pop && w_flags.rd_zero;

    assign w_sel = r_pend_x ? SEL_X : (r_pend_y ? SEL_Y : SEL_F);
    assign w_y_rd_addr = (w_sel == SEL_Y) ? r_y_addr : r_f_addr;

    assign w_old = (r_sel == SEL_X) ? r_x_q : r_y_q;
    assign w_dim = (r_sel == SEL_F) ? -r_im : r_im;
    assign w_new = r_is_read ? '0
                 : {sat_add(w_old[MW-1:ACC_BITS], r_re), sat_add(w_old[ACC_BITS-1:0], w_dim)};

    always_comb begin
        w_x_we = 1'b0;
        w_y_we = 1'b0;
        w_x_wa = r_x_addr;
        w_y_wa = (r_sel == SEL_Y) ? r_y_addr : r_f_addr;
        w_x_wd = w_new;
        w_y_wd = w_new;
        if (r_state == S_CLEAR) begin
            w_x_we = 32'(r_clr) < X_DEPTH;
            w_y_we = 32'(r_clr) < Y_DEPTH;
            w_x_wa = r_clr[AXW-1:0];
            w_y_wa = r_clr[AYW-1:0];
            w_x_wd = '0;
            w_y_wd = '0;
        end else if (r_state == S_WR) begin
            w_x_we = (r_sel == SEL_X);
            w_y_we = (r_sel != SEL_X);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_x_we) begin
            r_x_mem[w_x_wa] <= w_x_wd;
        end
        r_x_q <= r_x_mem[r_x_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_y_we) begin
            r_y_mem[w_y_wa] <= w_y_wd;
        end
        r_y_q <= r_y_mem[w_y_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pend_x <= 1'b0;
            r_pend_y <= 1'b0;
            r_pend_f <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == CW'(CLR_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_pend_x <= w_flags.do_x || w_flags.rd_x;
                        r_pend_y <= w_flags.do_y || w_flags.rd_y;
                        r_pend_f <= w_flags.do_f;
                        if (w_flags.do_x || w_flags.do_y || w_flags.do_f
                            || w_flags.rd_x || w_flags.rd_y) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    unique case (r_sel)
                        SEL_X:   r_pend_x <= 1'b0;
                        SEL_Y:   r_pend_y <= 1'b0;
                        default: r_pend_f <= 1'b0;
                    endcase
                    priority if (r_sel == SEL_X && (r_pend_y || r_pend_f)) begin
                        r_state <= S_RD;
                    end else if (r_sel == SEL_Y && r_pend_f) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_is_read <= w_flags.rd_x || w_flags.rd_y;
            r_x_addr  <= w_x_addr;
            r_y_addr  <= w_y_addr;
            r_f_addr  <= w_f_addr;
            r_re      <= w_re;
            r_im      <= w_im;
        end
        if (r_state == S_RD) begin
            r_sel <= w_sel;
        end
    end

    always_comb begin
        o_out_push = w_zero_push || ((r_state == S_WR) && r_is_read);
        if (w_zero_push) begin
            o_out_word = '0;
        end else begin
            o_out_word.bin_real = to_out(w_old[MW-1:ACC_BITS]);
            o_out_word.bin_imag = to_out(w_old[ACC_BITS-1:0]);
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into a full queue");
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("bin write without a preceding read");
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("command taken during the clearing pass");
    a_rd_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_pend_x || r_pend_y || r_pend_f))
        else $error("bin read started with nothing pending");
`endif

endmodule
`default_nettype wire

### rtl/cross_spectrum_accumulate.sv
// Top level of the cross spectrum accumulator with Hermitian folding.
//
//  channel   direction  handshake              payload
//  input     in         i_push / o_full        i_in_word  (csa_pkg::t_in_word)
//  result    out        o_empty / i_pop        o_out_word (csa_pkg::t_out_word)
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// The front stage registers the four products and classifies the registered word combinationally.
// The back runs each bin update as a read and a write of one store: it takes the
// command in S_IDLE, then passes S_RD and S_WR once per bin touched, up to three
// bins for an accumulate and one for a read; a read out of range gets a zero word.
// After reset a clearing pass over max(x depth, y depth) entries (8256 by default)
// zeroes the stores while full stays high. A stalled result port stops the back
// only once the result queue is full.
`default_nettype none
module cross_spectrum_accumulate #(
    parameter int MAX_X_POINTS = csa_pkg::DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = csa_pkg::DEF_MAX_Y_POINTS,
    parameter int LEVELS       = csa_pkg::DEF_LEVELS,
    parameter int ACC_BITS     = csa_pkg::DEF_ACC_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire csa_pkg::t_in_word         i_in_word,
    output logic                           o_full,
    output logic                           o_empty,
    input  wire logic                      i_pop,
    output csa_pkg::t_out_word             o_out_word,
    input  wire logic                      i_cfg_we,
    input  wire logic [0:0]                i_cfg_index,
    input  wire logic [csa_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int X_DEPTH = (MAX_X_POINTS / 2 + 1) * LEVELS;
    localparam int Y_DEPTH = (MAX_Y_POINTS / 2 + 1) * LEVELS;
    localparam int AXW     = $clog2(X_DEPTH);
    localparam int AYW     = $clog2(Y_DEPTH);
    localparam int CMD_W   = $bits(csa_pkg::t_cmd_flags) + AXW + 2 * AYW
                             + 2 * csa_pkg::PROD_W;
    localparam int OW      = $bits(csa_pkg::t_out_word);

    logic             w_q_push, w_q_full, w_q_empty, w_q_pop, w_clearing;
    logic [CMD_W-1:0] w_q_in, w_q_out;
    logic             w_out_push, w_out_full;
    csa_pkg::t_out_word w_out_word;
    logic [OW-1:0]    w_res_data;

    csa_front #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS),
        .LEVELS       (LEVELS),
        .AXW          (AXW),
        .AYW          (AYW),
        .CMD_W        (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in_word   (i_in_word),
        .o_full      (o_full),
        .i_hold      (w_clearing),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_q_push    (w_q_push),
        .i_q_full    (w_q_full),
        .o_q_data    (w_q_in)
    );

    csa_queue #(
        .W     (CMD_W),
        .DEPTH (csa_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_data  (w_q_out)
    );

    csa_back #(
        .ACC_BITS (ACC_BITS),
        .X_DEPTH  (X_DEPTH),
        .Y_DEPTH  (Y_DEPTH),
        .AXW      (AXW),
        .AYW      (AYW),
        .CMD_W    (CMD_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_out),
        .o_q_pop    (w_q_pop),
        .o_clearing (w_clearing),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_out_word (w_out_word)
    );

    csa_queue #(
        .W     (OW),
        .DEPTH (csa_pkg::RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_word),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_full  (w_out_full),
        .o_data  (w_res_data)
    );

    assign o_out_word = w_res_data;

endmodule
`default_nettype wire

### tb/sv/cross_spectrum_accumulate_tb.sv
// Self-checking cross spectrum accumulator bench: directed table, extreme inputs, random traffic.
`default_nettype none
module cross_spectrum_accumulate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int XMAX = 128;
    localparam int YMAX = 128;
    localparam int NLEV = 64;
    localparam int NWORDS = 950;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic signed [47:0] SAT_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SAT_LO = 48'sh8000_0000_0000;

    typedef struct {
        csa_pkg::t_in_word  word;
        logic               has_expect;
        csa_pkg::t_out_word expect_word;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    csa_pkg::t_in_word i_in_word = '0;
    logic o_full;
    logic o_empty;
    logic i_pop = 1'b0;
    csa_pkg::t_out_word o_out_word;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [csa_pkg::CFG_W-1:0] i_cfg_data = '0;

    logic signed [47:0] xb_re [(XMAX+1)*NLEV];
    logic signed [47:0] xb_im [(XMAX+1)*NLEV];
    logic signed [47:0] yb_re [(YMAX+1)*NLEV];
    logic signed [47:0] yb_im [(YMAX+1)*NLEV];
    logic [csa_pkg::CFG_W-1:0] nx_reg = csa_pkg::GRID_RESET;
    logic [csa_pkg::CFG_W-1:0] ny_reg = csa_pkg::GRID_RESET;

    csa_pkg::t_out_word bins_pending [$];
    csa_pkg::t_out_word typed_pending [$];
    logic typed_valid [$];
    int errors = 0;
    int pop_pct = 70;
    bit sending_done = 0;

    cross_spectrum_accumulate dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("cross_spectrum_accumulate_tb: errors");
        $finish;
    end

    function automatic int grid_size(logic [csa_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic logic signed [47:0] sat_sum(logic signed [47:0] a,
                                                   logic signed [63:0] d);
        logic signed [63:0] s;
        s = 64'(a) + d;
        if (s > 64'(SAT_HI)) return SAT_HI;
        if (s < 64'(SAT_LO)) return SAT_LO;
        return s[47:0];
    endfunction

    task automatic bin_read(input csa_pkg::t_in_word w, output csa_pkg::t_out_word r);
        int idx;
        r = '0;
        if (w.operation == csa_pkg::OP_READ_X) begin
            if (w.x_wave_index <= XMAX) begin
                idx = w.x_wave_index * NLEV + w.z_level;
                r.bin_real = xb_re[idx];
                r.bin_imag = xb_im[idx];
                xb_re[idx] = 0;
                xb_im[idx] = 0;
            end
        end else if (w.y_wave_index <= YMAX) begin
            idx = w.y_wave_index * NLEV + w.z_level;
            r.bin_real = yb_re[idx];
            r.bin_imag = yb_im[idx];
            yb_re[idx] = 0;
            yb_im[idx] = 0;
        end
    endtask

    // Sets has_res to 1 when the word produces a bin result.
    task automatic spectrum_update(input csa_pkg::t_in_word w, output bit has_res,
                                   output csa_pkg::t_out_word r);
        int nx, ny, ix, iy, k, niy, idx;
        logic signed [63:0] re, im;
        bit fold;
        has_res = 0;
        r = '0;
        if (w.operation == csa_pkg::OP_READ_X || w.operation == csa_pkg::OP_READ_Y) begin
            has_res = 1;
            bin_read(w, r);
            return;
        end
        if (w.operation != csa_pkg::OP_ACCUM) return;
        nx = grid_size(nx_reg);
        ny = grid_size(ny_reg);
        ix = w.x_wave_index;
        iy = w.y_wave_index;
        k = w.z_level;
        if (ix > nx / 2 || iy >= ny) return;
        re = 64'(w.u_real) * 64'(w.v_real) + 64'(w.u_imag) * 64'(w.v_imag);
        im = 64'(w.u_imag) * 64'(w.v_real) - 64'(w.u_real) * 64'(w.v_imag);
        niy = (ny - iy) % ny;
        if (!(ix == 0 && iy == 0)) begin
            idx = ix * NLEV + k;
            xb_re[idx] = sat_sum(xb_re[idx], re);
            xb_im[idx] = sat_sum(xb_im[idx], im);
        end
        fold = !(ix == nx / 2 && nx % 2 == 0);
        if (iy <= ny / 2 && (ix != 0 || iy > 0)) begin
            idx = iy * NLEV + k;
            yb_re[idx] = sat_sum(yb_re[idx], re);
            yb_im[idx] = sat_sum(yb_im[idx], im);
        end
        if (ix != 0 && fold && niy <= ny / 2) begin
            idx = niy * NLEV + k;
            yb_re[idx] = sat_sum(yb_re[idx], re);
            yb_im[idx] = sat_sum(yb_im[idx], -im);
        end
    endtask

    task automatic push_word(input csa_pkg::t_in_word w, input bit typed,
                             input csa_pkg::t_out_word tv);
        bit has_res;
        csa_pkg::t_out_word r;
        i_push <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_full);
        spectrum_update(w, has_res, r);
        if (has_res) begin
            bins_pending.push_back(r);
            typed_valid.push_back(typed);
            typed_pending.push_back(tv);
        end
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        i_push <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (bins_pending.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_grid(input logic [0:0] idx,
                              input logic [csa_pkg::CFG_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == csa_pkg::REG_GRID_X) nx_reg = v; else ny_reg = v;
    endtask

    function automatic csa_pkg::t_in_word make_word(logic [1:0] op, int ix, int iy, int k,
                                                    int ur, int ui, int vr, int vi);
        csa_pkg::t_in_word w;
        w.operation = op;
        w.x_wave_index = 8'(ix);
        w.y_wave_index = 8'(iy);
        w.z_level = 6'(k);
        w.u_real = 16'(ur);
        w.u_imag = 16'(ui);
        w.v_real = 16'(vr);
        w.v_imag = 16'(vi);
        return w;
    endfunction

    function automatic csa_pkg::t_in_word random_word(int nx, int ny);
        csa_pkg::t_in_word w;
        int r;
        w = csa_pkg::t_in_word'({$urandom, $urandom, $urandom});
        r = $urandom_range(0, 99);
        w.z_level = 6'($urandom_range(0, 3));
        if (r < 3) w.z_level = 6'($urandom);
        if (r < 60) begin
            w.operation = csa_pkg::OP_ACCUM;
            w.x_wave_index = 8'($urandom_range(0, nx / 2));
            w.y_wave_index = 8'($urandom_range(0, ny - 1));
            if (r < 5) w.x_wave_index = 8'($urandom);
            if (r < 15) begin
                w.u_real = 16'sh8000;
                w.v_real = 16'sh8000;
                w.u_imag = 16'sh8000;
                w.v_imag = 16'sh8000;
            end
        end else if (r < 97) begin
            w.operation = (r < 78) ? csa_pkg::OP_READ_X : csa_pkg::OP_READ_Y;
            if (r < 93) begin
                w.x_wave_index = 8'($urandom_range(0, nx / 2));
                w.y_wave_index = 8'($urandom_range(0, ny / 2));
            end
        end else begin
            w.operation = OP_NONE;
        end
        return w;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        csa_pkg::t_out_word e;
        if (i_rst_n && i_pop && !o_empty) begin
            if (bins_pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                errors++;
            end else begin
                e = bins_pending.pop_front();
                if (typed_valid.pop_front()) e = typed_pending.pop_front();
                else void'(typed_pending.pop_front());
                if (o_out_word.bin_real !== e.bin_real) begin
                    $display("%0t: bin_real expected %h actual %h", $time,
                             e.bin_real, o_out_word.bin_real);
                    errors++;
                end
                if (o_out_word.bin_imag !== e.bin_imag) begin
                    $display("%0t: bin_imag expected %h actual %h", $time,
                             e.bin_imag, o_out_word.bin_imag);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (sending_done) i_pop <= 1'b1;
        else i_pop <= ($urandom_range(0, 99) < pop_pct);
    end

    initial begin
        t_row rows [$];
        t_row row;
        csa_pkg::t_out_word sat_pos, sat_neg, zero_word;
        int sent, nx, ny, waits;
        foreach (xb_re[i]) begin
            xb_re[i] = 0; xb_im[i] = 0;
        end
        foreach (yb_re[i]) begin
            yb_re[i] = 0; yb_im[i] = 0;
        end
        zero_word = '0;
        sat_pos.bin_real = 48'sh0000_4000_0000;
        sat_pos.bin_imag = 48'sh0;
        sat_neg = zero_word;

        rows.push_back('{make_word(csa_pkg::OP_READ_X, 0, 0, 0, 0, 0, 0, 0), 1, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_Y, 0, 128, 63, 0, 0, 0, 0), 1,
                         zero_word});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 3, 5, 7, -32768, 0, -32768, 0), 0,
                         zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_X, 3, 0, 7, 0, 0, 0, 0), 1, sat_pos});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 0, 0, 1, 32767, -32768, 100, 32767),
                         0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 0, 4, 1, 32767, -32768, -1, 32767),
                         0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 128, 9, 2, 1234, -77, 32767, -32768),
                         0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 5, 250, 2, -32768, 32767, -32768,
                                   32767), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 129, 1, 2, 5, 5, 5, 5), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_ACCUM, 255, 255, 63, 5, 5, 5, 5), 0,
                         zero_word});
        rows.push_back('{make_word(OP_NONE, 1, 1, 1, 5, 5, 5, 5), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_X, 0, 0, 1, 0, 0, 0, 0), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_Y, 0, 4, 1, 0, 0, 0, 0), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_X, 128, 0, 2, 0, 0, 0, 0), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_Y, 0, 9, 2, 0, 0, 0, 0), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_Y, 0, 6, 2, 0, 0, 0, 0), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_X, 5, 0, 2, 0, 0, 0, 0), 0, zero_word});
        rows.push_back('{make_word(csa_pkg::OP_READ_X, 129, 0, 2, 0, 0, 0, 0), 1, sat_neg});
        rows.push_back('{make_word(csa_pkg::OP_READ_Y, 0, 255, 63, 0, 0, 0, 0), 1, sat_neg});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            push_word(row.word, row.has_expect, row.expect_word);
        end
        wait_drained();

        // Accumulate into the x and y bins of one point with extreme inputs, then read the bins back.
        for (int j = 0; j < 20; j++)
            push_word(make_word(csa_pkg::OP_ACCUM, 1, 1, 9, -32768, -32768, -32768, -32768),
                      0, zero_word);
        push_word(make_word(csa_pkg::OP_READ_X, 1, 0, 9, 0, 0, 0, 0), 0, zero_word);
        for (int j = 0; j < 20; j++)
            push_word(make_word(csa_pkg::OP_ACCUM, 1, 1, 9, -32768, 32767, 32767, 32767),
                      0, zero_word);
        push_word(make_word(csa_pkg::OP_READ_X, 1, 0, 9, 0, 0, 0, 0), 0, zero_word);
        push_word(make_word(csa_pkg::OP_READ_Y, 0, 1, 9, 0, 0, 0, 0), 0, zero_word);
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_grid(csa_pkg::REG_GRID_X, 9'd1);
                    write_grid(csa_pkg::REG_GRID_Y, 9'd0);
                end
                1: begin
                    write_grid(csa_pkg::REG_GRID_X, 9'd7);
                    write_grid(csa_pkg::REG_GRID_Y, 9'd6);
                end
                2: begin
                    write_grid(csa_pkg::REG_GRID_X, 9'd8);
                    write_grid(csa_pkg::REG_GRID_Y, 9'd5);
                end
                3: begin
                    write_grid(csa_pkg::REG_GRID_X, 9'h1FF);
                    write_grid(csa_pkg::REG_GRID_Y, 9'd300);
                end
                4: begin
                    write_grid(csa_pkg::REG_GRID_X, 9'd2);
                    write_grid(csa_pkg::REG_GRID_Y, 9'd1);
                end
                default: begin
                    write_grid(csa_pkg::REG_GRID_X, 9'd256);
                    write_grid(csa_pkg::REG_GRID_Y, 9'd256);
                end
            endcase
            nx = grid_size(nx_reg);
            ny = grid_size(ny_reg);
            pop_pct = (phase % 2) ? 100 : $urandom_range(20, 80);
            for (int j = 0; j < NWORDS / 6; j++) begin
                push_word(random_word(nx, ny), 0, zero_word);
                sent++;
                if ($urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 6));
                if (j == 80) wait_drained();
            end
            wait_drained();
        end

        sending_done = 1;
        waits = 0;
        while (bins_pending.size() != 0 && waits < 10000) begin
            @(negedge i_clk);
            waits++;
        end
        repeat (20) @(negedge i_clk);
        if (errors == 0 && bins_pending.size() == 0)
            $display("cross_spectrum_accumulate_tb: clean");
        else
            $display("cross_spectrum_accumulate_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
